>>> hdl/ncu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncu_pkg
// Shared types, constants and helpers for the triangle near clip unit.
// ----------------------------------------------------------------------------
package ncu_pkg;

  // one vertex: component 0 is x, 1 is y, 2 is z, each signed Q16.16
  typedef logic [2:0][31:0] vtx_t;
  // one triangle: vertex 0, 1, 2
  typedef logic [2:0][2:0][31:0] tv_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_SKIP = 2'd0,
    ST_VIS  = 2'd1,
    ST_REJ  = 2'd2,
    ST_ADD  = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TAN  = 2'd0,
    CFG_NEAR = 2'd1,
    CFG_FAR  = 2'd2
  } cfg_idx_t;

  localparam logic [30:0] TAN_RST  = 31'd65536;
  localparam logic [31:0] NEAR_RST = 32'd65536;
  localparam logic [31:0] FAR_RST  = 32'd65536000;

  // quotient bits of the edge parameter, and lane latency
  localparam int DIV_STEPS = 16;
  localparam int LANE_LAT  = DIV_STEPS + 3;

  // classified triangle traveling beside the lanes
  typedef struct packed {
    tv_t        v;
    logic       skip;
    logic       reject;
    logic [2:0] behind;
  } item_t;

  // one result item
  typedef struct packed {
    tv_t     v;
    status_t status;
    logic    last;
  } res_t;

  // endpoints of the two cut edges: lane 0 (a0 -> b0), lane 1 (a1 -> b1)
  typedef struct packed {
    logic [1:0] a0;
    logic [1:0] b0;
    logic [1:0] a1;
    logic [1:0] b1;
  } esel_t;

  function automatic esel_t edge_sel(input logic [2:0] behind);
    esel_t s;
    case (behind)
      3'd1:    s = '{a0: 2'd0, b0: 2'd1, a1: 2'd0, b1: 2'd2};
      3'd2:    s = '{a0: 2'd1, b0: 2'd0, a1: 2'd1, b1: 2'd2};
      3'd4:    s = '{a0: 2'd2, b0: 2'd0, a1: 2'd2, b1: 2'd1};
      3'd3:    s = '{a0: 2'd0, b0: 2'd2, a1: 2'd1, b1: 2'd2};
      3'd5:    s = '{a0: 2'd0, b0: 2'd1, a1: 2'd2, b1: 2'd1};
      3'd6:    s = '{a0: 2'd1, b0: 2'd0, a1: 2'd2, b1: 2'd0};
      default: s = '{a0: 2'd0, b0: 2'd1, a1: 2'd0, b1: 2'd2};
    endcase
    return s;
  endfunction

endpackage

>>> hdl/triangle_frustum_near_clip_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_frustum_near_clip_unit
// Near plane clipper: frustum test, edge cutting lanes for both cut edges, result merge.
// ----------------------------------------------------------------------------
// A triangle is taken every cycle while the output side keeps up; its first
// result passes through 3 classify stages, 19 lane stages and the output
// register, the first of them loaded at the accepting edge. A triangle
// split in two gives two results and holds the input while the second
// waits, so throughput is one result per cycle when not stalled,
// set by the single output register. The two lanes each run a
// 16-stage pipelined divider for the edge parameter. Configuration writes
// are always ready and take effect at once; write them only while idle.
// ----------------------------------------------------------------------------
module triangle_frustum_near_clip_unit import ncu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_a_x,
  input  logic [31:0] in_a_y,
  input  logic [31:0] in_a_z,
  input  logic [31:0] in_b_x,
  input  logic [31:0] in_b_y,
  input  logic [31:0] in_b_z,
  input  logic [31:0] in_c_x,
  input  logic [31:0] in_c_y,
  input  logic [31:0] in_c_z,
  input  logic        in_skip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_r_a_x,
  output logic [31:0] out_r_a_y,
  output logic [31:0] out_r_a_z,
  output logic [31:0] out_r_b_x,
  output logic [31:0] out_r_b_y,
  output logic [31:0] out_r_b_z,
  output logic [31:0] out_r_c_x,
  output logic [31:0] out_r_c_y,
  output logic [31:0] out_r_c_z,
  output logic [1:0]  out_status,
  output logic        out_is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [30:0] tan_r;
  logic [31:0] near_r, far_r;
  logic        adv;
  tv_t         in_v;
  logic        cls_vld;
  item_t       cls_item;
  vtx_t        l0p0, l0p1, l1p0, l1p1, i0, i1;
  logic        dl_vld_r [LANE_LAT];
  item_t       dl_r     [LANE_LAT];
  res_t        res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tan_r  <= TAN_RST;
      near_r <= NEAR_RST;
      far_r  <= FAR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TAN:  tan_r  <= cfg_data[30:0];
        CFG_NEAR: near_r <= cfg_data;
        CFG_FAR:  far_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !adv;
  assign in_v     = {{in_c_z, in_c_y, in_c_x}, {in_b_z, in_b_y, in_b_x},
                     {in_a_z, in_a_y, in_a_x}};

  // frustum test
  ncu_class u_class (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .in_vld       (in_valid),
    .in_v         (in_v),
    .in_skip      (in_skip),
    .tan_half_fov (tan_r),
    .near_z       ($signed(near_r)),
    .far_z        ($signed(far_r)),
    .vld          (cls_vld),
    .item         (cls_item),
    .l0_p0        (l0p0),
    .l0_p1        (l0p1),
    .l1_p0        (l1p0),
    .l1_p1        (l1p1)
  );

  // edge cutting lanes, one for each cut edge
  ncu_lane u_lane0 (
    .clk    (clk),
    .en     (adv),
    .near_z ($signed(near_r)),
    .p0     (l0p0),
    .p1     (l0p1),
    .cut    (i0)
  );

  ncu_lane u_lane1 (
    .clk    (clk),
    .en     (adv),
    .near_z ($signed(near_r)),
    .p0     (l1p0),
    .p1     (l1p1),
    .cut    (i1)
  );

  // classified item delay matching the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        dl_vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      dl_vld_r[0] <= cls_vld;
      for (int i = 1; i < LANE_LAT; i++) begin
        dl_vld_r[i] <= dl_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= cls_item;
      for (int i = 1; i < LANE_LAT; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  // result assembly and output register
  ncu_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (dl_vld_r[LANE_LAT-1]),
    .item      (dl_r[LANE_LAT-1]),
    .i0        (i0),
    .i1        (i1),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_r_a_x   = res.v[0][0];
  assign out_r_a_y   = res.v[0][1];
  assign out_r_a_z   = res.v[0][2];
  assign out_r_b_x   = res.v[1][0];
  assign out_r_b_y   = res.v[1][1];
  assign out_r_b_z   = res.v[1][2];
  assign out_r_c_x   = res.v[2][0];
  assign out_r_c_y   = res.v[2][1];
  assign out_r_c_z   = res.v[2][2];
  assign out_status  = res.status;
  assign out_is_last = res.last;

endmodule

>>> hdl/ncu_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncu_class
// Frustum test of the three vertices and choice of the two cut edges.
// ----------------------------------------------------------------------------
module ncu_class import ncu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  tv_t                in_v,
  input  logic               in_skip,
  input  logic [30:0]        tan_half_fov,
  input  logic signed [31:0] near_z,
  input  logic signed [31:0] far_z,
  output logic               vld,
  output item_t              item,
  output vtx_t               l0_p0,
  output vtx_t               l0_p1,
  output vtx_t               l1_p0,
  output vtx_t               l1_p1
);

  logic               vld1_r, vld2_r, vld3_r;
  tv_t                v1_r, v2_r;
  logic               skip1_r, skip2_r;
  logic signed [47:0] tz2_r [3];
  logic signed [63:0] prod_w [3];
  logic [2:0]         inside_w, behind_w;
  esel_t              sel_w;
  item_t              item_r, item_nxt;
  vtx_t               l0p0_r, l0p1_r, l1p0_r, l1p1_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= in_v;
      skip1_r <= in_skip;
    end
  end

  // frustum half width at each depth, floored
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_w[j] = $signed({1'b0, tan_half_fov}) * $signed(v1_r[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r    <= v1_r;
      skip2_r <= skip1_r;
      for (int j = 0; j < 3; j++) begin
        tz2_r[j] <= prod_w[j][63:16];
      end
    end
  end

  // inside and behind flags
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      inside_w[j] = ($signed({{16{v2_r[j][0][31]}}, v2_r[j][0]}) < tz2_r[j]) &&
                    ($signed({{16{v2_r[j][0][31]}}, v2_r[j][0]}) > -tz2_r[j]) &&
                    ($signed({{16{v2_r[j][1][31]}}, v2_r[j][1]}) < tz2_r[j]) &&
                    ($signed({{16{v2_r[j][1][31]}}, v2_r[j][1]}) > -tz2_r[j]) &&
                    ($signed(v2_r[j][2]) > near_z) && ($signed(v2_r[j][2]) < far_z);
      behind_w[j] = !inside_w[j] && ($signed(v2_r[j][2]) < near_z);
    end
    sel_w           = edge_sel(behind_w);
    item_nxt.v      = v2_r;
    item_nxt.skip   = skip2_r;
    item_nxt.reject = ~|inside_w;
    item_nxt.behind = behind_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
      l0p0_r <= v2_r[sel_w.a0];
      l0p1_r <= v2_r[sel_w.b0];
      l1p0_r <= v2_r[sel_w.a1];
      l1p1_r <= v2_r[sel_w.b1];
    end
  end

  assign vld   = vld3_r;
  assign item  = item_r;
  assign l0_p0 = l0p0_r;
  assign l0_p1 = l0p1_r;
  assign l1_p0 = l1p0_r;
  assign l1_p1 = l1p1_r;

endmodule

>>> hdl/ncu_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncu_lane
// Cuts one edge at the near plane: pipelined restoring divide for the edge
// parameter, then multiply and add per component with saturation.
// ----------------------------------------------------------------------------
module ncu_lane import ncu_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] near_z,
  input  vtx_t               p0,
  input  vtx_t               p1,
  output vtx_t               cut
);

  logic signed [32:0] num_w, den_w;
  logic               t_zero_w, t_one_w;

  logic [31:0]              rem_r [DIV_STEPS+1];
  logic [31:0]              den_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]     q_r   [DIV_STEPS+1];
  logic [1:0]               fl_r  [DIV_STEPS+1];
  logic [2:0][32:0]         d_r   [DIV_STEPS+1];
  vtx_t                     p0_r  [DIV_STEPS+1];

  logic [DIV_STEPS:0]       t_w;
  logic signed [50:0]       prod_r [3];
  vtx_t                     p0m_r;
  logic signed [35:0]       sum_w [3];
  vtx_t                     cut_r;

  // numerator, denominator and the degenerate edge cases
  always_comb begin
    num_w    = $signed({near_z[31], near_z}) - $signed({p0[2][31], p0[2]});
    den_w    = $signed({p1[2][31], p1[2]}) - $signed({p0[2][31], p0[2]});
    t_zero_w = (num_w <= 33'sd0);
    t_one_w  = !t_zero_w && ((den_w <= 33'sd0) || (num_w >= den_w));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_w[31:0];
      den_r[0] <= den_w[31:0];
      q_r[0]   <= '0;
      fl_r[0]  <= {t_one_w, t_zero_w};
      p0_r[0]  <= p0;
      for (int k = 0; k < 3; k++) begin
        d_r[0][k] <= {p1[k][31], p1[k]} - {p0[k][31], p0[k]};
      end
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [32:0] sh_w, diff_w;
    logic        ge_w;
    assign sh_w   = {rem_r[i], 1'b0};
    assign diff_w = sh_w - {1'b0, den_r[i]};
    assign ge_w   = (sh_w >= {1'b0, den_r[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge_w ? diff_w[31:0] : sh_w[31:0];
        den_r[i+1] <= den_r[i];
        q_r[i+1]   <= {q_r[i][DIV_STEPS-2:0], ge_w};
        fl_r[i+1]  <= fl_r[i];
        d_r[i+1]   <= d_r[i];
        p0_r[i+1]  <= p0_r[i];
      end
    end
  end

  // edge parameter in 0 .. 1.0
  always_comb begin
    if (fl_r[DIV_STEPS][1]) begin
      t_w = {1'b1, {DIV_STEPS{1'b0}}};
    end else if (fl_r[DIV_STEPS][0]) begin
      t_w = '0;
    end else begin
      t_w = {1'b0, q_r[DIV_STEPS]};
    end
  end

  // delta times parameter
  always_ff @(posedge clk) begin
    if (en) begin
      p0m_r <= p0_r[DIV_STEPS];
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= $signed(d_r[DIV_STEPS][k]) * $signed({1'b0, t_w});
      end
    end
  end

  // floor, add and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_w[k] = $signed({{4{p0m_r[k][31]}}, p0m_r[k]}) +
                 $signed({prod_r[k][50], prod_r[k][50:16]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (sum_w[k] > 36'sd2147483647) begin
          cut_r[k] <= 32'h7FFF_FFFF;
        end else if (sum_w[k] < -36'sd2147483648) begin
          cut_r[k] <= 32'h8000_0000;
        end else begin
          cut_r[k] <= sum_w[k][31:0];
        end
      end
    end
  end

  assign cut = cut_r;

endmodule

>>> hdl/ncu_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncu_merge
// Builds the result triangles from the lane cut points and holds them in
// an output register plus one pending slot for the added triangle.
// ----------------------------------------------------------------------------
module ncu_merge import ncu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  item_t item,
  input  vtx_t  i0,
  input  vtx_t  i1,
  input  logic  out_stall,
  output logic  adv,
  output logic  out_valid,
  output res_t  out_res
);

  logic out_vld_r, out_vld_nxt, pend_vld_r, pend_vld_nxt;
  res_t out_r, pend_r;
  res_t r0_w, r1_w;
  logic two_w;

  assign adv = !out_vld_r || (!out_stall && !pend_vld_r);

  // result shapes per case
  always_comb begin
    r0_w.v      = item.v;
    r0_w.status = ST_VIS;
    r0_w.last   = 1'b1;
    r1_w.v      = item.v;
    r1_w.status = ST_ADD;
    r1_w.last   = 1'b1;
    two_w       = 1'b0;
    if (item.skip) begin
      r0_w.status = ST_SKIP;
    end else if (item.reject) begin
      r0_w.status = ST_REJ;
    end else begin
      case (item.behind)
        3'd1: begin
          r0_w.v = {item.v[2], i0, i1};
          r1_w.v = {item.v[2], item.v[1], i0};
          two_w  = 1'b1;
        end
        3'd2: begin
          r0_w.v = {item.v[2], i1, i0};
          r1_w.v = {item.v[0], item.v[2], i0};
          two_w  = 1'b1;
        end
        3'd4: begin
          r0_w.v = {i0, i1, item.v[0]};
          r1_w.v = {item.v[1], item.v[0], i1};
          two_w  = 1'b1;
        end
        3'd3:    r0_w.v = {item.v[2], i1, i0};
        3'd5:    r0_w.v = {i1, item.v[1], i0};
        3'd6:    r0_w.v = {i1, i0, item.v[0]};
        default: r0_w.v = item.v;
      endcase
      r0_w.last = !two_w;
    end
  end

  // output and pending slot control
  always_comb begin
    out_vld_nxt  = out_vld_r;
    pend_vld_nxt = pend_vld_r;
    if (out_vld_r && !out_stall) begin
      out_vld_nxt  = pend_vld_r;
      pend_vld_nxt = 1'b0;
    end
    if (adv && in_vld) begin
      out_vld_nxt  = 1'b1;
      pend_vld_nxt = two_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      out_r  <= r0_w;
      pend_r <= r1_w;
    end else if (out_vld_r && !out_stall && pend_vld_r) begin
      out_r <= pend_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

  // pending slot only behind a shown result
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> out_vld_r)
    else $error("pending result without output result");

  // a non-final result always has its partner queued
  a_first_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.last) |-> pend_vld_r)
    else $error("first of two results without second queued");

  // the pipeline holds while the added triangle waits
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> !adv)
    else $error("pipeline advanced over pending result");

  // the added triangle always closes its item
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == ST_ADD) |-> out_r.last)
    else $error("added triangle not last");

endmodule
